FILE: hdl/sliding_window_sum_meter_core_macros.svh
// Assertion macros for the sliding window sum meter.
// Used by the controller and datapath; depends on nothing.
`ifndef SLIDING_WINDOW_SUM_METER_CORE_MACROS_SVH
`define SLIDING_WINDOW_SUM_METER_CORE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define SWSM_ASSERT_IMP(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define SWSM_ASSERT_NEXT(label, clk_s, rst_n, ante, cons) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: hdl/swsm_pkg.sv
// Shared types and constants for the sliding window sum meter.
// No dependencies.
`default_nettype none
package swsm_pkg;
	localparam int RING_DEPTH = 64;
	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int TIME_W = 48;
	localparam int VAL_W = 48;
	localparam int SUM_W = 56;
	localparam int DIV_STEPS = 48;
	localparam logic [2:0] REG_WINDOW = 3'd0;
	localparam logic [2:0] REG_MIN_GAP = 3'd1;
	localparam logic [2:0] REG_TIMED = 3'd2;
	localparam logic [2:0] REG_LOAD = 3'd3;
	localparam logic [2:0] REG_BW = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SCALE, ST_DIV, ST_FIX, ST_PRUNE_RD, ST_PRUNE_CHK,
		ST_STORE, ST_DONE, ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic div_start;
		logic div_step;
		logic fix;
		logic rd_oldest;
		logic drop;
		logic store;
		logic finish;
		logic evict;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_flush;
		logic load_mode;
		logic prune_en;
		logic count_zero;
		logic count_full;
		logic expired;
		logic div_last;
	} ctrl_stat_t;
endpackage
`default_nettype wire

FILE: hdl/swsm_if.sv
// Valid/ready channel interfaces for the meter.
// Depends on nothing.
`default_nettype none
interface swsm_in_if (input wire logic clk);
	logic valid;
	logic ready;
	logic action;
	logic [47:0] timestamp;
	logic signed [31:0] sample_value;
	modport source(output valid, action, timestamp, sample_value, input ready);
	modport sink(input valid, action, timestamp, sample_value, output ready);
endinterface

interface swsm_out_if (input wire logic clk);
	logic valid;
	logic ready;
	logic signed [55:0] window_sum;
	logic emitted;
	logic [47:0] emit_time;
	logic dropped_oldest;
	modport source(output valid, window_sum, emitted, emit_time, dropped_oldest,
		input ready);
	modport sink(input valid, window_sum, emitted, emit_time, dropped_oldest,
		output ready);
endinterface

interface swsm_cfg_if (input wire logic clk);
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [31:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: hdl/swsm_ctrl.sv
// Controller state machine of the meter.
// Depends on swsm_pkg and the assertion macro header.
`default_nettype none
`include "sliding_window_sum_meter_core_macros.svh"
module swsm_ctrl
	import swsm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	input wire ctrl_stat_t stat,
	output ctrl_cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (!stat.is_flush && stat.load_mode) begin
					cmd.mul = 1'b1;
					state_d = ST_DIV;
				end else state_d = ST_PRUNE_RD;
			end
			ST_DIV: begin
				cmd.div_start = 1'b1;
				state_d = ST_FIX;
			end
			ST_FIX: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_PRUNE_RD;
				end
			end
			ST_PRUNE_RD: begin
				cmd.fix = 1'b1;
				cmd.rd_oldest = 1'b1;
				state_d = ST_PRUNE_CHK;
			end
			ST_PRUNE_CHK: begin
				if (stat.prune_en && !stat.count_zero && stat.expired) begin
					cmd.drop = 1'b1;
					state_d = ST_PRUNE_RD;
				end else state_d = ST_STORE;
			end
			ST_STORE: begin
				// full ring: drop the oldest first, its value still held from the last prune read
				if (!stat.is_flush && stat.count_full) begin
					cmd.drop = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.store = !stat.is_flush;
					state_d = ST_OUT;
					cmd.finish = 1'b1;
				end
			end
			ST_DONE: begin
				cmd.store = 1'b1;
				cmd.finish = 1'b1;
				cmd.evict = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`SWSM_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, state_q == ST_IDLE)
	`SWSM_ASSERT_IMP(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	`SWSM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule
`default_nettype wire

FILE: hdl/swsm_dp.sv
// Datapath of the meter: registers, ring memory, serial divider, sum.
// Depends on swsm_pkg and the assertion macro header.
`default_nettype none
`include "sliding_window_sum_meter_core_macros.svh"
module swsm_dp
	import swsm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [2:0] cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic in_action,
	input wire logic [TIME_W-1:0] in_timestamp,
	input wire logic signed [31:0] in_sample,
	input wire ctrl_cmd_t cmd,
	output ctrl_stat_t stat,
	output logic signed [SUM_W-1:0] window_sum,
	output logic emitted,
	output logic [TIME_W-1:0] emit_time,
	output logic dropped_oldest
);
	logic [31:0] window_q, min_gap_q, bw_q;
	logic timed_q, load_q;
	logic action_q;
	logic [TIME_W-1:0] ts_q;
	logic signed [31:0] samp_q;
	logic [VAL_W-1:0] val_q;
	logic neg_q;
	logic [VAL_W-1:0] mag_q, quo_q;
	logic [32:0] rem_q;
	logic [5:0] step_q;
	logic [IDX_W-1:0] oldest_q;
	logic [CNT_W-1:0] count_q;
	logic [SUM_W-1:0] sum_q;
	logic [TIME_W-1:0] last_emit_q;
	logic has_emit_q;
	logic [TIME_W-1:0] rd_time_q;
	logic [VAL_W-1:0] rd_val_q;
	logic [TIME_W-1:0] mem_time [RING_DEPTH];
	logic [VAL_W-1:0] mem_val [RING_DEPTH];

	logic [31:0] bw_eff;
	logic [TIME_W-1:0] cutoff;
	logic [IDX_W-1:0] wr_idx;
	logic [32:0] rem_sh;
	logic [31:0] samp_mag;
	logic emit_now;

	assign bw_eff = (bw_q == 32'd0) ? 32'd1 : bw_q;
	assign cutoff = ts_q - {16'd0, window_q};
	assign wr_idx = oldest_q + count_q[IDX_W-1:0];
	assign rem_sh = {rem_q[31:0], mag_q[VAL_W-1]};
	assign samp_mag = samp_q[31] ? 32'(-samp_q) : 32'(samp_q);

	always_comb begin
		emit_now = 1'b0;
		if (action_q || !timed_q) begin
			if (!has_emit_q) emit_now = 1'b1;
			else if (ts_q > {16'd0, min_gap_q}
				&& last_emit_q < ts_q - {16'd0, min_gap_q}) emit_now = 1'b1;
		end
	end

	always_comb begin
		stat.is_flush = action_q;
		stat.load_mode = load_q;
		stat.prune_en = ts_q > {16'd0, window_q};
		stat.count_zero = count_q == '0;
		stat.count_full = count_q == CNT_W'(RING_DEPTH);
		stat.expired = rd_time_q < cutoff;
		stat.div_last = step_q == 6'(DIV_STEPS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= 32'd1000;
			min_gap_q <= '0;
			timed_q <= 1'b0;
			load_q <= 1'b0;
			bw_q <= 32'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW: window_q <= cfg_data;
				REG_MIN_GAP: min_gap_q <= cfg_data;
				REG_TIMED: timed_q <= cfg_data[0];
				REG_LOAD: load_q <= cfg_data[0];
				REG_BW: bw_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item registers and divider
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= in_action;
			ts_q <= in_timestamp;
			samp_q <= in_sample;
			val_q <= VAL_W'(signed'(in_sample));
		end
		if (cmd.mul) begin
			neg_q <= samp_q[31];
			// magnitude times 25600 = 2^14 + 2^13 + 2^10
			mag_q <= {2'd0, samp_mag, 14'd0} + {3'd0, samp_mag, 13'd0}
				+ {6'd0, samp_mag, 10'd0};
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			step_q <= '0;
		end
		if (cmd.div_step) begin
			step_q <= step_q + 6'd1;
			mag_q <= {mag_q[VAL_W-2:0], 1'b0};
			if (rem_sh >= {1'b0, bw_eff}) begin
				rem_q <= rem_sh - {1'b0, bw_eff};
				quo_q <= {quo_q[VAL_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[VAL_W-2:0], 1'b0};
			end
		end
		if (cmd.fix && !action_q && load_q && step_q == 6'(DIV_STEPS)) begin
			val_q <= neg_q ? -quo_q : quo_q;
			step_q <= '0;
		end
		if (cmd.rd_oldest || cmd.drop) begin
			rd_time_q <= mem_time[cmd.drop ? oldest_q + IDX_W'(1) : oldest_q];
			rd_val_q <= mem_val[cmd.drop ? oldest_q + IDX_W'(1) : oldest_q];
		end
		if (cmd.store) begin
			mem_time[wr_idx] <= ts_q;
			mem_val[wr_idx] <= val_q;
		end
		if (cmd.finish) begin
			emitted <= emit_now;
			emit_time <= emit_now ? ts_q : '0;
			dropped_oldest <= cmd.evict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q <= '0;
			count_q <= '0;
			sum_q <= '0;
			last_emit_q <= '0;
			has_emit_q <= 1'b0;
		end else begin
			if (cmd.drop && !cmd.store) begin
				oldest_q <= oldest_q + IDX_W'(1);
				count_q <= count_q - CNT_W'(1);
				sum_q <= sum_q - SUM_W'(signed'(rd_val_q));
			end
			if (cmd.store && !cmd.drop) begin
				count_q <= count_q + CNT_W'(1);
				sum_q <= sum_q + SUM_W'(signed'(val_q));
			end
			if (cmd.finish && emit_now) begin
				last_emit_q <= ts_q;
				has_emit_q <= 1'b1;
			end
		end
	end

	assign window_sum = sum_q;

	`SWSM_ASSERT_IMP(a_count_range, clk, arst_n, 1'b1, count_q <= CNT_W'(RING_DEPTH))
	`SWSM_ASSERT_IMP(a_drop_nonempty, clk, arst_n, cmd.drop, count_q != '0)
	`SWSM_ASSERT_IMP(a_store_room, clk, arst_n, cmd.store, count_q != CNT_W'(RING_DEPTH))
endmodule
`default_nettype wire

FILE: hdl/sliding_window_sum_meter_core.sv
// Top level of the sliding window sum meter.
// Depends on swsm_pkg, swsm_if, swsm_ctrl and swsm_dp.
// Usage:
//   in_ch  : sample or flush requests (action, timestamp, sample_value).
//   out_ch : one result request per input (window_sum, emitted, emit_time,
//            dropped_oldest).
//   cfg_ch : register writes, index 0..4, taken every cycle; write only
//            while no item is in flight.
// Each item first prunes expired ring entries, one at a time starting at
// the oldest, then stores the sample (dropping the oldest if the ring
// holds 64 entries; a flush stores nothing). In load mode the sample is
// scaled by a 48-step restoring divider first. One item is processed at
// a time; the next request is taken only after the result has been
// accepted.
// Reset clears the ring to empty and loads register defaults. While the
// receiver stalls, hold the result steady and accept no new input.
`default_nettype none
module sliding_window_sum_meter_core
	import swsm_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	swsm_in_if.sink in_ch,
	swsm_out_if.source out_ch,
	swsm_cfg_if.sink cfg_ch
);
	ctrl_cmd_t cmd;
	ctrl_stat_t stat;

	assign cfg_ch.ready = 1'b1;

	swsm_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat(stat), .cmd(cmd)
	);

	swsm_dp u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
		.in_action(in_ch.action), .in_timestamp(in_ch.timestamp),
		.in_sample(in_ch.sample_value),
		.cmd(cmd), .stat(stat),
		.window_sum(out_ch.window_sum), .emitted(out_ch.emitted),
		.emit_time(out_ch.emit_time), .dropped_oldest(out_ch.dropped_oldest)
	);
endmodule
`default_nettype wire

FILE: tb/tb_sliding_window_sum_meter_core.sv
// Self-checking testbench for sliding_window_sum_meter_core: a directed table, then random phases.
// Each result is checked against a predictor of the sliding window sum.
// Depends on swsm_pkg, swsm_if and the core RTL.
`default_nettype none
module tb_sliding_window_sum_meter_core;
	import swsm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic ACT_SAMPLE = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;
	localparam int RANDOM_ITEMS = 1550;
	localparam int IDLE_LIMIT = 5000;
	localparam int LONG_HOLD = 300;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One result request of the meter.
	typedef struct packed {
		logic [55:0] window_sum;
		logic emitted;
		logic [47:0] emit_time;
		logic dropped_oldest;
	} meter_result_t;

	// One row of the directed table: either a request or a register write.
	typedef struct {
		row_kind_t kind;
		logic action;
		logic [47:0] timestamp;
		logic [31:0] sample_value;
		logic [2:0] reg_index;
		logic [31:0] reg_data;
		bit typed;
		meter_result_t typed_result;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	swsm_in_if in_ch(clk);
	swsm_out_if out_ch(clk);
	swsm_cfg_if cfg_ch(clk);

	sliding_window_sum_meter_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	always #5 clk = ~clk;

	// Register copy held by the predictor.
	logic [31:0] window_ticks;
	logic [31:0] min_gap_ticks;
	logic timed_mode;
	logic load_mode;
	logic [31:0] link_bandwidth;

	// Ring copy held by the predictor.
	logic [47:0] ring_time [RING_DEPTH];
	logic [47:0] ring_value [RING_DEPTH];
	logic [IDX_W-1:0] ring_head;
	int ring_fill;
	logic [55:0] sum_acc;
	logic [47:0] last_emit;
	bit emitted_once;

	meter_result_t pending_results[$];
	stim_row_t directed_rows[$];
	int fail_count = 0;
	int idle_cycles = 0;
	bit hold_request = 0;

	// Remove the oldest ring entry from the ring and from the sum.
	task automatic retire_oldest();
		sum_acc = sum_acc - {{8{ring_value[ring_head][47]}}, ring_value[ring_head]};
		ring_head = ring_head + 1'b1;
		ring_fill--;
	endtask

	// Work out the result of one accepted request and advance the predictor state.
	task automatic meter_step(input logic action, input logic [47:0] ts,
			input logic [31:0] sample, output meter_result_t res);
		logic [63:0] scaled;
		logic [63:0] mag;
		logic [63:0] bw;
		longint signed num;
		logic [IDX_W-1:0] slot;
		bit fire;
		res = '0;
		fire = 0;
		// Drop expired entries from the oldest on; stop at the first one still in the window.
		if (ts > {16'd0, window_ticks}) begin
			while (ring_fill > 0 && ring_time[ring_head] < ts - {16'd0, window_ticks})
				retire_oldest();
		end
		if (action == ACT_SAMPLE) begin
			if (load_mode) begin
				bw = (link_bandwidth == 0) ? 64'd1 : {32'd0, link_bandwidth};
				num = longint'($signed(sample)) * 25600;
				mag = (num < 0) ? 64'(-num) : 64'(num);
				scaled = (num < 0) ? -(mag / bw) : (mag / bw);
			end else begin
				scaled = 64'(longint'($signed(sample)));
			end
			// A full ring loses its oldest entry to make room.
			if (ring_fill >= RING_DEPTH) begin
				retire_oldest();
				res.dropped_oldest = 1'b1;
			end
			slot = ring_head + IDX_W'(ring_fill);
			ring_time[slot] = ts;
			ring_value[slot] = scaled[47:0];
			ring_fill++;
			sum_acc = sum_acc + {{8{scaled[47]}}, scaled[47:0]};
		end
		if (action == ACT_FLUSH || !timed_mode) begin
			if (!emitted_once)
				fire = 1;
			else if (ts > {16'd0, min_gap_ticks} && last_emit < ts - {16'd0, min_gap_ticks})
				fire = 1;
			if (fire) begin
				last_emit = ts;
				emitted_once = 1;
			end
		end
		res.window_sum = sum_acc;
		res.emitted = fire;
		res.emit_time = fire ? ts : 48'd0;
	endtask

	// Offer one request; record its expected result once it is taken.
	task automatic send_request(input logic action, input logic [47:0] ts,
			input logic [31:0] sample, input bit typed, input meter_result_t typed_res);
		meter_result_t res;
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.action <= action;
		in_ch.timestamp <= ts;
		in_ch.sample_value <= sample;
		do @(posedge clk); while (!in_ch.ready);
		meter_step(action, ts, sample, res);
		pending_results.insert(pending_results.size(), typed ? typed_res : res);
	endtask

	// Lower valid and idle for a number of cycles.
	task automatic pause_sender(input int cycles);
		@(negedge clk);
		in_ch.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// Wait until every outstanding result has arrived, then let the core settle.
	task automatic drain_results();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	// Write one register; only called once the core is idle.
	task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_WINDOW: window_ticks = data;
			REG_MIN_GAP: min_gap_ticks = data;
			REG_TIMED: timed_mode = data[0];
			REG_LOAD: load_mode = data[0];
			REG_BW: link_bandwidth = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic add_request(input logic action, input logic [47:0] ts, input logic [31:0] sample);
		stim_row_t r;
		r = '{kind: ROW_ITEM, action: action, timestamp: ts, sample_value: sample,
			reg_index: REG_WINDOW, reg_data: '0, typed: 0, typed_result: '0};
		directed_rows.insert(directed_rows.size(), r);
	endtask

	task automatic add_typed(input logic action, input logic [47:0] ts, input logic [31:0] sample,
			input meter_result_t res);
		stim_row_t r;
		r = '{kind: ROW_ITEM, action: action, timestamp: ts, sample_value: sample,
			reg_index: REG_WINDOW, reg_data: '0, typed: 1, typed_result: res};
		directed_rows.insert(directed_rows.size(), r);
	endtask

	task automatic add_write(input logic [2:0] idx, input logic [31:0] data);
		stim_row_t r;
		r = '{kind: ROW_CFG, action: ACT_SAMPLE, timestamp: '0, sample_value: '0,
			reg_index: idx, reg_data: data, typed: 0, typed_result: '0};
		directed_rows.insert(directed_rows.size(), r);
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(0, 200)) - 100);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_ticks(input bit wide);
		case ($urandom_range(0, 6))
			0: return 32'd0;
			1: return 32'hffff_ffff;
			2: return 32'd1;
			3: return $urandom;
			default: return wide ? $urandom_range(50, 5000) : $urandom_range(0, 40);
		endcase
	endfunction

	// Receiver: ready follows one of four randomly picked patterns, or holds off on request.
	initial begin
		int mode;
		int tick;
		out_ch.ready = 1'b0;
		mode = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_request = 0;
			end else begin
				if (tick % 64 == 0)
					mode = $urandom_range(0, 3);
				tick++;
				case (mode)
					0: out_ch.ready <= 1'b1;
					1: out_ch.ready <= ($urandom_range(0, 1) == 0);
					2: out_ch.ready <= ($urandom_range(0, 9) != 0);
					default: out_ch.ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// Check each accepted result against the oldest expectation.
	always @(posedge clk) begin
		meter_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: window_sum %0d", out_ch.window_sum);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (out_ch.window_sum !== want.window_sum) begin
					$error("window_sum expected %0d actual %0d",
						$signed(want.window_sum), out_ch.window_sum);
					fail_count++;
				end
				if (out_ch.emitted !== want.emitted) begin
					$error("emitted expected %0d actual %0d", want.emitted, out_ch.emitted);
					fail_count++;
				end
				if (out_ch.emit_time !== want.emit_time) begin
					$error("emit_time expected %0d actual %0d", want.emit_time, out_ch.emit_time);
					fail_count++;
				end
				if (out_ch.dropped_oldest !== want.dropped_oldest) begin
					$error("dropped_oldest expected %0d actual %0d",
						want.dropped_oldest, out_ch.dropped_oldest);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		logic [47:0] now;
		logic [47:0] span;
		logic act;
		int sent;
		int burst_left;
		int phase_len;
		int phase_no;
		in_ch.valid = 1'b0;
		in_ch.action = ACT_SAMPLE;
		in_ch.timestamp = '0;
		in_ch.sample_value = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_WINDOW;
		cfg_ch.data = '0;
		// Register and ring values after reset.
		window_ticks = 32'd1000;
		min_gap_ticks = 32'd0;
		timed_mode = 1'b0;
		load_mode = 1'b0;
		link_bandwidth = 32'd1;
		ring_head = '0;
		ring_fill = 0;
		sum_acc = '0;
		last_emit = '0;
		emitted_once = 0;

		// Directed table. Typed rows: first sample after reset, and a flush that expires all.
		add_typed(ACT_SAMPLE, 48'd0, 32'd5, '{56'd5, 1'b1, 48'd0, 1'b0});
		add_request(ACT_SAMPLE, 48'd0, 32'h8000_0000);
		add_request(ACT_SAMPLE, 48'd10, 32'h7fff_ffff);
		add_request(ACT_FLUSH, 48'd10, 32'hdead_beef);
		add_typed(ACT_FLUSH, 48'd2000, 32'd0, '{56'd0, 1'b1, 48'd2000, 1'b0});
		add_request(ACT_SAMPLE, 48'd2000, 32'd0);
		// Out-of-order timestamp: pruning stops at the first entry in the window.
		add_request(ACT_SAMPLE, 48'd1500, 32'd3);
		// Early time: no pruning while timestamp is within the window.
		add_write(REG_WINDOW, 32'hffff_ffff);
		add_request(ACT_SAMPLE, 48'd2100, 32'hffff_ffff);
		// Load mode with zero bandwidth divides by one, so samples scale by 25600.
		add_write(REG_LOAD, 32'd1);
		add_write(REG_BW, 32'd0);
		add_request(ACT_SAMPLE, 48'd3000, 32'hffff_fff9);
		add_request(ACT_SAMPLE, 48'd3000, 32'h7fff_ffff);
		add_write(REG_BW, 32'hffff_ffff);
		add_request(ACT_SAMPLE, 48'd3001, 32'h8000_0000);
		add_write(REG_BW, 32'd3);
		add_request(ACT_SAMPLE, 48'd3002, 32'hffff_ffff);
		// Timed mode, largest gap: only flushes emit; gap test blocks the one at 4000.
		add_write(REG_TIMED, 32'd1);
		add_write(REG_MIN_GAP, 32'hffff_ffff);
		add_request(ACT_SAMPLE, 48'd4000, 32'd7);
		add_request(ACT_FLUSH, 48'd4000, 32'd0);
		add_request(ACT_FLUSH, 48'hffff_ffff_ffff, 32'd0);
		add_write(REG_WINDOW, 32'd0);
		add_write(REG_LOAD, 32'd0);
		add_request(ACT_SAMPLE, 48'hffff_ffff_ffff, 32'h7fff_ffff);
		add_request(ACT_FLUSH, 48'hffff_ffff_ffff, 32'd0);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain_results();
				write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
			end else begin
				send_request(directed_rows[i].action, directed_rows[i].timestamp,
					directed_rows[i].sample_value, directed_rows[i].typed,
					directed_rows[i].typed_result);
			end
		end

		// Random phases: settle, rewrite every register, then a stretch of requests.
		sent = 0;
		phase_no = 0;
		now = 48'd0;
		while (sent < RANDOM_ITEMS) begin
			drain_results();
			write_register(REG_WINDOW, pick_ticks(1));
			write_register(REG_MIN_GAP, pick_ticks(0));
			write_register(REG_TIMED, 32'($urandom_range(0, 3) == 0));
			write_register(REG_LOAD, 32'($urandom_range(0, 2) == 0));
			write_register(REG_BW, pick_ticks($urandom_range(0, 1)));
			if ($urandom_range(0, 4) == 0)
				now = 48'({$urandom, $urandom});
			case ($urandom_range(0, 3))
				0: span = 48'd0;
				1: span = 48'd3;
				2: span = {16'd0, window_ticks} >> 6;
				default: span = 48'($urandom_range(0, 5000));
			endcase
			phase_len = $urandom_range(20, 90);
			// One phase stalls the receiver long enough that the core stops taking input.
			if (phase_no == 2)
				hold_request = 1;
			burst_left = $urandom_range(1, 20);
			repeat (phase_len) begin
				if ($urandom_range(0, 19) == 0)
					now = now - 48'($urandom_range(0, 300));
				else
					now = now + 48'($urandom_range(0, 32'(span > 48'hffff_ffff ? 48'hffff_ffff : span)));
				act = ($urandom_range(0, 3) == 0) ? ACT_FLUSH : ACT_SAMPLE;
				send_request(act, now, pick_sample(), 0, '0);
				sent++;
				burst_left--;
				if (burst_left == 0) begin
					pause_sender($urandom_range(1, 8));
					burst_left = $urandom_range(1, 20);
				end
			end
			phase_no++;
		end

		drain_results();
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
